/* rtl/ct_pkg.sv */
// Shared types and constants for the columnar transposition block.
// No dependencies; imported by ct_div and columnar_transposition_top.
package ct_pkg;

    localparam int BYTE_W = 8;
    localparam int CFG_W  = 5;  // widest register: row_width

    localparam logic REG_ROW_WIDTH = 1'b0;
    localparam logic REG_DECRYPT   = 1'b1;

    typedef enum logic [2:0] {
        ST_LOAD = 3'b001,
        ST_DIV  = 3'b010,
        ST_EMIT = 3'b100
    } ct_state_t;

endpackage

/* rtl/columnar_transposition_top.sv */
// Columnar transposition: one byte accepted per cycle while loading, then tready
// drops for the division (length by width) and for the emission, which leaves one
// byte per cycle while the output accepts (one memory read port) and ends at the last read.
// The first result is valid once the divider is done and its memory read is registered and buffered.
// Reset: asynchronous, active low; clears counters, flags and control, not the
// message memory. row_width resets to 6, decrypt_mode to 0.
module columnar_transposition_top
    import ct_pkg::*;
#(
    parameter int MAX_LEN   = 64,
    parameter int MAX_WIDTH = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [BYTE_W-1:0] s_axis_tdata,   // [7:0] data_byte
    input  logic              s_axis_tlast,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [BYTE_W-1:0] m_axis_tdata,   // [7:0] out_byte
    output logic              m_axis_tlast,
    output logic              m_axis_tuser,   // [0] overflow
    input  logic              cfg_we,
    input  logic              cfg_idx,
    input  logic [CFG_W-1:0]  cfg_wdata
);

    localparam int CNT_W  = $clog2(MAX_LEN + 1);
    localparam int ADDR_W = $clog2(MAX_LEN);
    localparam int WMAX   = (MAX_WIDTH < 31) ? MAX_WIDTH : 31;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
        logic              ovf;
    } out_item_t;

    logic [BYTE_W-1:0] mem [MAX_LEN];
    logic [BYTE_W-1:0] mem_q_reg;

    ct_state_t         state_reg, state_next;
    logic [CFG_W-1:0]  row_width_reg;
    logic              decrypt_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              ovf_reg;

    logic [CNT_W-1:0]  n_reg;
    logic              msg_ovf_reg;
    logic              msg_dec_reg;
    logic [CFG_W-1:0]  w_reg;
    logic [CNT_W-1:0]  rows_reg;
    logic [CFG_W-1:0]  rmd_reg;

    logic [CNT_W-1:0]  k_reg;
    logic [CFG_W-1:0]  col_reg, col_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  row_reg, row_next;
    logic [CNT_W-1:0]  pos_reg, pos_next;

    logic              pend_reg;
    logic              pend_last_reg;
    logic              pend_ovf_reg;
    out_item_t         fifo [2];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        fifo_cnt_reg;

    logic              in_fire;
    logic              full;
    logic [CNT_W-1:0]  n_in;
    logic [CFG_W-1:0]  eff_w;
    logic              div_done;
    logic [CNT_W-1:0]  div_quot;
    logic [CFG_W-1:0]  div_rem;
    logic              pop;
    logic [1:0]        occ;
    logic              rd_en;
    logic              last_issue;
    logic [ADDR_W-1:0] rd_addr;
    logic [CNT_W:0]    enc_sum;
    logic              short_col;
    logic [CNT_W-1:0]  col_len;

    assign s_axis_tready = (state_reg == ST_LOAD);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign full          = (cnt_reg >= CNT_W'(MAX_LEN));
    assign n_in          = full ? cnt_reg : cnt_reg + 1'b1;

    always_comb
    begin
        if (row_width_reg == '0)
            eff_w = CFG_W'(1);
        else if (row_width_reg > CFG_W'(WMAX))
            eff_w = CFG_W'(WMAX);
        else
            eff_w = row_width_reg;
    end

    // config port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg <= CFG_W'(6);
            decrypt_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_ROW_WIDTH: row_width_reg <= cfg_wdata;
                REG_DECRYPT:   decrypt_reg   <= cfg_wdata[0];
                default:       ;
            endcase
        end
    end

    ct_div #(.CNT_W(CNT_W)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (in_fire && s_axis_tlast),
        .dividend (n_in),
        .divisor  (eff_w),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    // output buffer credit: pending read plus stored items must fit two slots
    assign pop        = m_axis_tvalid && m_axis_tready;
    assign occ        = fifo_cnt_reg + {1'b0, pend_reg};
    assign rd_en      = (state_reg == ST_EMIT) && ((occ < 2'd2) || pop);
    assign last_issue = (k_reg == n_reg - 1'b1);
    assign rd_addr    = msg_dec_reg ? pos_reg[ADDR_W-1:0] : idx_reg[ADDR_W-1:0];

    // walk of the column-major order of the row-major grid
    assign enc_sum   = {1'b0, idx_reg} + (CNT_W+1)'(w_reg);
    assign short_col = (rmd_reg != '0) && (col_reg >= rmd_reg);
    assign col_len   = rows_reg - CNT_W'(short_col);

    always_comb
    begin
        col_next = col_reg;
        idx_next = idx_reg;
        row_next = row_reg;
        pos_next = pos_reg;
        if (!msg_dec_reg)
        begin
            if (enc_sum < {1'b0, n_reg})
                idx_next = enc_sum[CNT_W-1:0];
            else
            begin
                col_next = col_reg + 1'b1;
                idx_next = CNT_W'(col_reg) + 1'b1;
            end
        end
        else
        begin
            // decrypt: output in row-major order, fetch from column-major slot
            if (({1'b0, col_reg} + 1'b1) < {1'b0, w_reg})
            begin
                col_next = col_reg + 1'b1;
                pos_next = pos_reg + col_len;
            end
            else
            begin
                col_next = '0;
                row_next = row_reg + 1'b1;
                pos_next = row_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD: if (in_fire && s_axis_tlast) state_next = ST_DIV;
            ST_DIV:  if (div_done) state_next = ST_EMIT;
            ST_EMIT: if (rd_en && last_issue) state_next = ST_LOAD;
            default: state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            cnt_reg      <= '0;
            ovf_reg      <= 1'b0;
            pend_reg     <= 1'b0;
            wr_ptr_reg   <= 1'b0;
            rd_ptr_reg   <= 1'b0;
            fifo_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_fire)
            begin
                if (s_axis_tlast)
                begin
                    cnt_reg <= '0;
                    ovf_reg <= 1'b0;
                end
                else
                begin
                    cnt_reg <= n_in;
                    ovf_reg <= ovf_reg | full;
                end
            end
            pend_reg <= rd_en;
            if (pend_reg)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            fifo_cnt_reg <= fifo_cnt_reg + {1'b0, pend_reg} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && !full)
            mem[cnt_reg[ADDR_W-1:0]] <= s_axis_tdata;
        if (rd_en)
            mem_q_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && s_axis_tlast)
        begin
            n_reg       <= n_in;
            msg_ovf_reg <= ovf_reg | full;
            msg_dec_reg <= decrypt_reg;
            w_reg       <= eff_w;
        end
        if (div_done)
        begin
            // rows of the grid, counting a short last row
            rows_reg <= div_quot + CNT_W'(div_rem != '0);
            rmd_reg  <= div_rem;
            k_reg    <= '0;
            col_reg  <= '0;
            idx_reg  <= '0;
            row_reg  <= '0;
            pos_reg  <= '0;
        end
        else if (rd_en)
        begin
            k_reg   <= k_reg + 1'b1;
            col_reg <= col_next;
            idx_reg <= idx_next;
            row_reg <= row_next;
            pos_reg <= pos_next;
        end
        if (rd_en)
        begin
            pend_last_reg <= last_issue;
            pend_ovf_reg  <= msg_ovf_reg;
        end
        if (pend_reg)
            fifo[wr_ptr_reg] <= '{data: mem_q_reg, last: pend_last_reg, ovf: pend_ovf_reg};
    end

    assign m_axis_tvalid = (fifo_cnt_reg != '0);
    assign m_axis_tdata  = fifo[rd_ptr_reg].data;
    assign m_axis_tlast  = fifo[rd_ptr_reg].last;
    assign m_axis_tuser  = fifo[rd_ptr_reg].ovf;

    a_credit: assert property (@(posedge clk) disable iff (!rst_n)
        (fifo_cnt_reg + {1'b0, pend_reg}) <= 2'd2)
        else $error("output buffer overcommitted");

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_LEN))
        else $error("byte count beyond buffer");

    a_read: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |=> pend_reg)
        else $error("issued read lost");

    a_nopop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_EMIT) |-> !rd_en)
        else $error("memory read outside emission");

endmodule

/* rtl/ct_div.sv */
// Restoring divider, one quotient bit per cycle: message length by row width.
// Depends on ct_pkg (CFG_W).
module ct_div
    import ct_pkg::*;
#(
    parameter int CNT_W = 7
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [CNT_W-1:0] dividend,
    input  logic [CFG_W-1:0] divisor,
    output logic             done,
    output logic [CNT_W-1:0] quot,
    output logic [CFG_W-1:0] rem
);

    localparam int ITER_W = $clog2(CNT_W + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [ITER_W-1:0] iter_reg;
    logic [CNT_W-1:0]  dvd_reg;
    logic [CFG_W-1:0]  dvs_reg;
    logic [CFG_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  quo_reg;
    logic [CFG_W:0]    trial;
    logic              fits;

    assign trial = {rem_reg, dvd_reg[CNT_W-1]};
    assign fits  = (trial >= {1'b0, dvs_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                iter_reg <= ITER_W'(CNT_W);
            end
            else if (busy_reg)
            begin
                iter_reg <= iter_reg - 1'b1;
                if (iter_reg == ITER_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[CNT_W-2:0], 1'b0};
            quo_reg <= {quo_reg[CNT_W-2:0], fits};
            if (fits)
                rem_reg <= CFG_W'(trial - {1'b0, dvs_reg});
            else
                rem_reg <= trial[CFG_W-1:0];
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;
    assign rem  = rem_reg;

endmodule

/* verif/tb_top.sv */
// Self-checking bench for columnar_transposition_top: directed messages, then random ones.
// Depends on rtl/ct_pkg.sv and rtl/columnar_transposition_top.sv; the checker below
// recomputes each permuted message from the accepted bytes, save directed rows that give the expected byte.
module tb_top
    import ct_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int BUF_DEPTH  = 64;
    localparam int KEY_MAX    = 16;
    localparam int RAND_ITEMS = 265;
    localparam int SETTLE     = 40;
    localparam int LIMIT      = 200000;

    typedef struct {
        logic [BYTE_W-1:0] data;
        logic              last;
        logic              ovf;
    } cipher_byte_t;

    typedef enum logic {ROW_CFG, ROW_MSG} row_kind_t;

    // one directed step: a register write, or a message of counting bytes
    typedef struct packed {
        row_kind_t         kind;
        logic              reg_idx;
        logic [CFG_W-1:0]  value;
        logic [BYTE_W-1:0] data;
        logic [6:0]        count;
        logic              typed;
        logic [BYTE_W-1:0] want;
    } dir_row_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [BYTE_W-1:0] s_axis_tdata;    // [7:0] data_byte
    logic              s_axis_tlast;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [BYTE_W-1:0] m_axis_tdata;    // [7:0] out_byte
    logic              m_axis_tlast;
    logic              m_axis_tuser;    // [0] overflow
    logic              cfg_we;
    logic              cfg_idx;
    logic [CFG_W-1:0]  cfg_wdata;

    // checker state
    logic [BYTE_W-1:0] msg_buf [BUF_DEPTH];
    int                msg_len;
    logic              msg_dropped;
    logic [CFG_W-1:0]  key_width;
    logic              decrypt_on;
    cipher_byte_t      cipher_out_q [$];

    int  errors;
    int  cycles;
    bit  tx_quiet;
    bit  rx_quiet;

    dir_row_t plan [19] = '{
        '{ROW_MSG, REG_ROW_WIDTH, 5'd0,  8'h00, 7'd1,  1'b1, 8'h00},
        '{ROW_MSG, REG_ROW_WIDTH, 5'd0,  8'hFF, 7'd1,  1'b1, 8'hFF},
        '{ROW_MSG, REG_ROW_WIDTH, 5'd0,  8'h10, 7'd12, 1'b0, 8'h00},
        '{ROW_MSG, REG_ROW_WIDTH, 5'd0,  8'h20, 7'd4,  1'b0, 8'h00},
        '{ROW_CFG, REG_ROW_WIDTH, 5'd0,  8'h00, 7'd0,  1'b0, 8'h00},
        '{ROW_MSG, REG_ROW_WIDTH, 5'd0,  8'h30, 7'd3,  1'b0, 8'h00},
        '{ROW_CFG, REG_ROW_WIDTH, 5'd31, 8'h00, 7'd0,  1'b0, 8'h00},
        '{ROW_MSG, REG_ROW_WIDTH, 5'd0,  8'h40, 7'd20, 1'b0, 8'h00},
        '{ROW_CFG, REG_DECRYPT,   5'h1F, 8'h00, 7'd0,  1'b0, 8'h00},
        '{ROW_MSG, REG_ROW_WIDTH, 5'd0,  8'h40, 7'd20, 1'b0, 8'h00},
        '{ROW_CFG, REG_ROW_WIDTH, 5'd5,  8'h00, 7'd0,  1'b0, 8'h00},
        '{ROW_MSG, REG_ROW_WIDTH, 5'd0,  8'h50, 7'd13, 1'b0, 8'h00},
        '{ROW_CFG, REG_ROW_WIDTH, 5'd16, 8'h00, 7'd0,  1'b0, 8'h00},
        '{ROW_MSG, REG_ROW_WIDTH, 5'd0,  8'h80, 7'd66, 1'b0, 8'h00},
        '{ROW_CFG, REG_DECRYPT,   5'h1E, 8'h00, 7'd0,  1'b0, 8'h00},
        '{ROW_CFG, REG_ROW_WIDTH, 5'd1,  8'h00, 7'd0,  1'b0, 8'h00},
        '{ROW_MSG, REG_ROW_WIDTH, 5'd0,  8'hE0, 7'd1,  1'b1, 8'hE0},
        '{ROW_CFG, REG_ROW_WIDTH, 5'd17, 8'h00, 7'd0,  1'b0, 8'h00},
        '{ROW_MSG, REG_ROW_WIDTH, 5'd0,  8'hC0, 7'd64, 1'b0, 8'h00}
    };

    columnar_transposition_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_idx       (cfg_idx),
        .cfg_wdata     (cfg_wdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= LIMIT)
        begin
            $display("%0t: timeout, %0d bytes still expected", $time, cipher_out_q.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic int draw_wait(input bit quiet);
        return quiet ? 0 : int'($urandom_range(0, 7));
    endfunction

    // Buffer one accepted byte; on the last one queue the permuted message.
    function automatic void take_byte(input logic [BYTE_W-1:0] b, input logic l,
                                      input bit typed, input logic [BYTE_W-1:0] want);
        logic [BYTE_W-1:0] perm [BUF_DEPTH];
        cipher_byte_t      r;
        int                w;
        int                rows;
        int                pos;
        int                idx;
        if (msg_len < BUF_DEPTH)
        begin
            msg_buf[msg_len] = b;
            msg_len++;
        end
        else
            msg_dropped = 1'b1;
        if (!l)
            return;
        w = (key_width == '0) ? 1 : ((key_width > KEY_MAX) ? KEY_MAX : int'(key_width));
        rows = (msg_len + w - 1) / w;
        pos = 0;
        // column-major walk of the row-major grid; short last row skipped
        for (int c = 0; c < w; c++)
            for (int rw = 0; rw < rows; rw++)
            begin
                idx = rw * w + c;
                if (idx < msg_len)
                begin
                    if (decrypt_on)
                        perm[idx] = msg_buf[pos];
                    else
                        perm[pos] = msg_buf[idx];
                    pos++;
                end
            end
        if (typed)
        begin
            r.data = want;
            r.last = 1'b1;
            r.ovf  = 1'b0;
            cipher_out_q.push_back(r);
        end
        else
            for (int k = 0; k < msg_len; k++)
            begin
                r.data = perm[k];
                r.last = (k == msg_len - 1);
                r.ovf  = msg_dropped;
                cipher_out_q.push_back(r);
            end
        msg_len     = 0;
        msg_dropped = 1'b0;
    endfunction

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic l,
                             input bit typed, input logic [BYTE_W-1:0] want);
        int gap;
        gap = draw_wait(tx_quiet);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= l;
        do @(posedge clk); while (s_axis_tready !== 1'b1);
        take_byte(b, l, typed, want);
        @(negedge clk);
    endtask

    // sender holds off until the block has emitted everything
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (cipher_out_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_ROW_WIDTH)
            key_width = val;
        else
            decrypt_on = val[0];
        @(negedge clk);
    endtask

    // output side: random stalls, check every transaction against the queue
    initial
    begin
        cipher_byte_t exp;
        int           stall;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = draw_wait(rx_quiet);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (m_axis_tvalid !== 1'b1);
            if (cipher_out_q.size() == 0)
            begin
                $display("%0t: expected no output, got data %h last %b ovf %b", $time,
                         m_axis_tdata, m_axis_tlast, m_axis_tuser);
                errors++;
            end
            else
            begin
                exp = cipher_out_q.pop_front();
                if (m_axis_tdata !== exp.data)
                begin
                    $display("%0t: data expected %h actual %h", $time, exp.data, m_axis_tdata);
                    errors++;
                end
                if (m_axis_tlast !== exp.last)
                begin
                    $display("%0t: last expected %b actual %b", $time, exp.last, m_axis_tlast);
                    errors++;
                end
                if (m_axis_tuser !== exp.ovf)
                begin
                    $display("%0t: overflow expected %b actual %b", $time, exp.ovf,
                             m_axis_tuser);
                    errors++;
                end
            end
            @(negedge clk);
        end
    end

    initial
    begin
        int len;
        int sent;
        int pick;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        cfg_we        = 1'b0;
        cfg_idx       = REG_ROW_WIDTH;
        cfg_wdata     = '0;
        msg_len       = 0;
        msg_dropped   = 1'b0;
        key_width     = 5'd6;
        decrypt_on    = 1'b0;
        errors        = 0;
        cycles        = 0;
        tx_quiet      = 1'b0;
        rx_quiet      = 1'b0;
        sent          = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CFG)
            begin
                wait_drained();
                write_reg(plan[i].reg_idx, plan[i].value);
            end
            else
                for (int k = 0; k < int'(plan[i].count); k++)
                    send_byte(8'(plan[i].data + k), k == int'(plan[i].count) - 1,
                              plan[i].typed, plan[i].want);
        end

        while (sent < RAND_ITEMS)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                wait_drained();
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    write_reg(REG_ROW_WIDTH, 5'd0);
                else if (pick == 1)
                    write_reg(REG_ROW_WIDTH, 5'd31);
                else if (pick == 2)
                    write_reg(REG_ROW_WIDTH, 5'($urandom_range(17, 30)));
                else
                    write_reg(REG_ROW_WIDTH, 5'($urandom_range(1, 16)));
                write_reg(REG_DECRYPT, 5'($urandom_range(0, 31)));
            end
            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet = ($urandom_range(0, 3) == 0);
            // mostly short messages, now and then one near, at or beyond the buffer size
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 24);
            for (int k = 0; k < len; k++)
                send_byte(8'($urandom_range(0, 255)), k == len - 1, 1'b0, 8'h00);
            sent += len;
        end

        wait_drained();
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
